// ----- hdl/nrid_pkg.sv -----
// Shared types and constants for the nibble run-length image decoder.
// No dependencies; imported by every module of the block.
package nrid_pkg;

  localparam int unsigned LINE_PIXELS = 320;
  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned WIDTH_BITS  = 9;
  localparam int unsigned HEIGHT_BITS = 16;
  localparam int unsigned PAL_BITS    = 24;
  localparam int unsigned COLOR_BITS  = 4;
  localparam int unsigned POS_BITS    = WIDTH_BITS + HEIGHT_BITS;
  localparam int unsigned Q_DEPTH     = 2;

  localparam logic [1:0] CFG_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_PALETTE = 2'd2;

  localparam logic [2:0] KIND_SKIP    = 3'd6;
  localparam logic [2:0] KIND_LITERAL = 3'd7;
  localparam logic [3:0] CNT_ESCAPE   = 4'hF;
  localparam logic [7:0] BYTE_ESCAPE  = 8'hFF;
  localparam logic [COUNT_BITS-1:0] SHORT_BIAS = COUNT_BITS'(2);
  localparam logic [COUNT_BITS-1:0] BYTE_BIAS  = COUNT_BITS'(17);
  localparam logic [2:0] WORD_NIBBLES = 3'd4;

  typedef struct packed {
    logic [WIDTH_BITS-1:0]  width;
    logic [HEIGHT_BITS-1:0] height;
    logic [PAL_BITS-1:0]    palette;
    logic                   restart;
  } cfg_t;

  typedef struct packed {
    logic                  first;
    logic                  stream_end;
    logic                  ready;
    logic [COUNT_BITS-1:0] count;
    logic [COLOR_BITS-1:0] color;
    logic                  transp;
  } run_t;

endpackage

// ----- hdl/nrid_fifo.sv -----
// Short queue of classified words between the front and back parts.
// Uses nrid_pkg for the entry type and depth.
module nrid_fifo import nrid_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  run_t data_i,
  output logic full_o,
  input  logic pop_i,
  output run_t data_o,
  output logic empty_o
);

  localparam int unsigned AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CW = $clog2(Q_DEPTH + 1);

  run_t            mem_q [Q_DEPTH];
  logic [AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(Q_DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(Q_DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- hdl/nrid_front.sv -----
// Front part: takes command nibbles, parses colour and count fields, and
// queues one classified word per nibble. Uses nrid_pkg.
module nrid_front import nrid_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [3:0]            nibble_i,
  input  logic                  first_i,
  input  logic                  stream_end_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output run_t                  entry_o
);

  typedef enum logic [5:0] {
    PH_CMD    = 6'b000001,
    PH_COLOR  = 6'b000010,
    PH_CNT1   = 6'b000100,
    PH_CNT_HI = 6'b001000,
    PH_CNT_LO = 6'b010000,
    PH_WORD   = 6'b100000
  } phase_e;

  phase_e                phase_q, phase_d, ph;
  logic [3:0]            cmd_q, cmd_d;
  logic [COLOR_BITS-1:0] color_q, color_d;
  logic [COUNT_BITS-1:0] acc_q, acc_d;
  logic [2:0]            left_q, left_d;
  logic                  ready;
  logic [COUNT_BITS-1:0] count;
  logic [7:0]            byte_val;
  logic [PAL_BITS-1:0]   pal_shift;
  logic                  transp;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign byte_val   = {acc_q[3:0], nibble_i};
  assign pal_shift  = cfg_i.palette >> {nibble_i[2:0], 2'b00};

  always_comb begin
    ph      = first_i ? PH_CMD : phase_q;
    phase_d = phase_q;
    cmd_d   = cmd_q;
    color_d = color_q;
    acc_d   = acc_q;
    left_d  = left_q;
    ready   = 1'b0;
    count   = '0;
    unique case (ph)
      PH_CMD: begin
        cmd_d = nibble_i;
        if (nibble_i[2:0] == KIND_LITERAL) begin
          phase_d = PH_COLOR;
        end else begin
          color_d = (nibble_i[2:0] < KIND_SKIP) ? pal_shift[COLOR_BITS-1:0] : '0;
          if (nibble_i[3]) begin
            phase_d = PH_CNT1;
          end else begin
            count = COUNT_BITS'(1);
            ready = 1'b1;
          end
        end
      end
      PH_COLOR: begin
        color_d = nibble_i;
        if (cmd_q[3]) begin
          phase_d = PH_CNT1;
        end else begin
          count = COUNT_BITS'(1);
          ready = 1'b1;
        end
      end
      PH_CNT1: begin
        if (nibble_i != CNT_ESCAPE) begin
          count = COUNT_BITS'(nibble_i) + SHORT_BIAS;
          ready = 1'b1;
        end else begin
          phase_d = PH_CNT_HI;
        end
      end
      PH_CNT_HI: begin
        acc_d   = COUNT_BITS'(nibble_i);
        phase_d = PH_CNT_LO;
      end
      PH_CNT_LO: begin
        if (byte_val != BYTE_ESCAPE) begin
          acc_d = COUNT_BITS'(byte_val);
          count = COUNT_BITS'(byte_val) + BYTE_BIAS;
          ready = 1'b1;
        end else begin
          acc_d   = '0;
          left_d  = WORD_NIBBLES;
          phase_d = PH_WORD;
        end
      end
      PH_WORD: begin
        acc_d  = {acc_q[COUNT_BITS-5:0], nibble_i};
        left_d = left_q - 3'd1;
        if (left_d == 3'd0) begin
          count = acc_d;
          ready = 1'b1;
        end
      end
      default: phase_d = PH_CMD;
    endcase
    if (ready) begin
      phase_d = PH_CMD;
    end
  end

  assign transp = (cmd_d[2:0] == KIND_SKIP);

  always_comb begin
    entry_o.first      = first_i;
    entry_o.stream_end = stream_end_i;
    entry_o.ready      = ready;
    entry_o.count      = count;
    entry_o.color      = transp ? '0 : color_d;
    entry_o.transp     = transp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CMD;
      cmd_q   <= '0;
      color_q <= '0;
      acc_q   <= '0;
      left_q  <= '0;
    end else if (cfg_i.restart) begin
      phase_q <= PH_CMD;
      cmd_q   <= '0;
      color_q <= '0;
      acc_q   <= '0;
      left_q  <= '0;
    end else if (push_o) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      color_q <= color_d;
      acc_q   <= acc_d;
      left_q  <= left_d;
    end
  end

endmodule

// ----- hdl/nrid_back.sv -----
// Back part: checks runs against the image bounds, splits them into row
// segments with an iterative divider, and drives the result register. Uses nrid_pkg.
module nrid_back import nrid_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   q_empty_i,
  input  run_t                   entry_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [HEIGHT_BITS-1:0] row_o,
  output logic [WIDTH_BITS-1:0]  column_o,
  output logic [WIDTH_BITS-1:0]  length_o,
  output logic [COUNT_BITS-1:0]  row_repeat_o,
  output logic [COLOR_BITS-1:0]  color_o,
  output logic                   transparent_o,
  output logic                   row_complete_o,
  output logic                   image_done_o,
  output logic                   error_o,
  output logic                   last_o
);

  localparam int unsigned IT_BITS = $clog2(COUNT_BITS);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ERR   = 7'b0000010,
    ST_CHECK = 7'b0000100,
    ST_SEG1  = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_MID   = 7'b0100000,
    ST_TAIL  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [HEIGHT_BITS-1:0] row;
    logic [WIDTH_BITS-1:0]  column;
    logic [WIDTH_BITS-1:0]  length;
    logic [COUNT_BITS-1:0]  row_repeat;
    logic [COLOR_BITS-1:0]  color;
    logic                   transparent;
    logic                   row_complete;
    logic                   image_done;
    logic                   error;
    logic                   last;
  } result_t;

  state_e                 state_q, state_d;
  run_t                   ent_q, ent_d;
  logic [HEIGHT_BITS-1:0] row_q, row_d;
  logic [WIDTH_BITS-1:0]  col_q, col_d;
  logic [POS_BITS-1:0]    pos_q, pos_d, total_q;
  logic                   failed_q, failed_d, finished_q, finished_d, done_q, done_d;
  logic [COUNT_BITS-1:0]  rem_q, rem_d, quo_q, quo_d;
  logic [WIDTH_BITS-1:0]  len_q, len_d, prt_q, prt_d;
  logic                   full1_q, full1_d;
  logic [IT_BITS-1:0]     it_q, it_d;
  logic                   out_valid_q, out_valid_d, out_load, out_free;
  result_t                res_q, res_d;

  logic [WIDTH_BITS-1:0]  w_eff;
  logic [HEIGHT_BITS-1:0] h_eff;
  logic [POS_BITS-1:0]    area;
  logic [POS_BITS-1:0]    cnt_ext, room_left, pos_sum;
  logic [WIDTH_BITS-1:0]  room;
  logic [WIDTH_BITS:0]    trial;
  logic                   ge, bad, done_now;

  always_comb begin
    w_eff = cfg_i.width;
    if (w_eff == '0) begin
      w_eff = WIDTH_BITS'(1);
    end else if (32'(cfg_i.width) > LINE_PIXELS) begin
      w_eff = WIDTH_BITS'(LINE_PIXELS);
    end
    h_eff = (cfg_i.height == '0) ? HEIGHT_BITS'(1) : cfg_i.height;
    area  = POS_BITS'(w_eff) * POS_BITS'(h_eff);
  end

  function automatic state_e after_head(logic [COUNT_BITS-1:0] rem,
                                        logic [WIDTH_BITS-1:0] w);
    if (rem == '0) begin
      return ST_IDLE;
    end else if (rem >= COUNT_BITS'(w)) begin
      return ST_DIV;
    end
    return ST_TAIL;
  endfunction

  assign out_free  = !out_valid_q || !out_stall_i;
  assign pop_o     = (state_q == ST_IDLE) && !q_empty_i;
  assign cnt_ext   = POS_BITS'(ent_q.count);
  assign room_left = total_q - pos_q;
  assign pos_sum   = pos_q + cnt_ext;
  assign bad       = (ent_q.count == '0) || (cnt_ext > room_left);
  assign done_now  = (pos_sum == total_q);
  assign room      = w_eff - col_q;
  assign trial     = {prt_q, quo_q[COUNT_BITS-1]};
  assign ge        = (trial >= {1'b0, w_eff});

  always_comb begin
    state_d    = state_q;
    ent_d      = ent_q;
    row_d      = row_q;
    col_d      = col_q;
    pos_d      = pos_q;
    failed_d   = failed_q;
    finished_d = finished_q;
    done_d     = done_q;
    rem_d      = rem_q;
    len_d      = len_q;
    full1_d    = full1_q;
    quo_d      = quo_q;
    prt_d      = prt_q;
    it_d       = it_q;
    out_load   = 1'b0;
    res_d      = '0;
    res_d.row         = row_q;
    res_d.column      = col_q;
    res_d.color       = ent_q.color;
    res_d.transparent = ent_q.transp;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          ent_d = entry_i;
          if (entry_i.first) begin
            row_d      = '0;
            col_d      = '0;
            pos_d      = '0;
            failed_d   = 1'b0;
            finished_d = 1'b0;
          end
          if (failed_d) begin
            state_d = ST_ERR;
          end else if (finished_d) begin
            state_d = ST_IDLE;
          end else if (!entry_i.ready) begin
            if (entry_i.stream_end) begin
              failed_d = 1'b1;
              state_d  = ST_ERR;
            end
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_ERR: begin
        res_d             = '0;
        res_d.row         = row_q;
        res_d.column      = col_q;
        res_d.error       = 1'b1;
        res_d.last        = 1'b1;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (bad || (ent_q.stream_end && !done_now)) begin
          failed_d = 1'b1;
          state_d  = ST_ERR;
        end else begin
          pos_d      = pos_sum;
          finished_d = done_now;
          done_d     = done_now;
          quo_d      = ent_q.count;
          prt_d      = '0;
          it_d       = '0;
          if (col_q != '0) begin
            full1_d = (ent_q.count >= COUNT_BITS'(room));
            len_d   = full1_d ? room : ent_q.count[WIDTH_BITS-1:0];
            rem_d   = ent_q.count - COUNT_BITS'(len_d);
            state_d = ST_SEG1;
          end else begin
            rem_d   = ent_q.count;
            state_d = after_head(ent_q.count, w_eff);
          end
        end
      end
      ST_SEG1: begin
        res_d.length       = len_q;
        res_d.row_repeat   = COUNT_BITS'(1);
        res_d.row_complete = full1_q;
        res_d.last         = (rem_q == '0);
        res_d.image_done   = (rem_q == '0) && done_q;
        quo_d = rem_q;
        prt_d = '0;
        it_d  = '0;
        if (out_free) begin
          out_load = 1'b1;
          if (full1_q) begin
            row_d = row_q + HEIGHT_BITS'(1);
            col_d = '0;
          end else begin
            col_d = col_q + len_q;
          end
          state_d = after_head(rem_q, w_eff);
        end
      end
      ST_DIV: begin
        prt_d = ge ? WIDTH_BITS'(trial - {1'b0, w_eff}) : trial[WIDTH_BITS-1:0];
        quo_d = {quo_q[COUNT_BITS-2:0], ge};
        it_d  = it_q + IT_BITS'(1);
        if (it_q == IT_BITS'(COUNT_BITS - 1)) begin
          state_d = ST_MID;
        end
      end
      ST_MID: begin
        res_d.column       = '0;
        res_d.length       = w_eff;
        res_d.row_repeat   = quo_q;
        res_d.row_complete = 1'b1;
        res_d.last         = (prt_q == '0);
        res_d.image_done   = (prt_q == '0) && done_q;
        if (out_free) begin
          out_load = 1'b1;
          row_d    = row_q + quo_q;
          rem_d    = COUNT_BITS'(prt_q);
          state_d  = (prt_q == '0) ? ST_IDLE : ST_TAIL;
        end
      end
      ST_TAIL: begin
        res_d.length     = rem_q[WIDTH_BITS-1:0];
        res_d.row_repeat = COUNT_BITS'(1);
        res_d.last       = 1'b1;
        res_d.image_done = done_q;
        if (out_free) begin
          out_load = 1'b1;
          col_d    = col_q + rem_q[WIDTH_BITS-1:0];
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      pos_q       <= '0;
      total_q     <= POS_BITS'(1);
      failed_q    <= 1'b0;
      finished_q  <= 1'b0;
      done_q      <= 1'b0;
      it_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      total_q     <= area;
      done_q      <= done_d;
      it_q        <= it_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.restart) begin
        state_q    <= ST_IDLE;
        row_q      <= '0;
        col_q      <= '0;
        pos_q      <= '0;
        failed_q   <= 1'b0;
        finished_q <= 1'b0;
      end else begin
        state_q    <= state_d;
        row_q      <= row_d;
        col_q      <= col_d;
        pos_q      <= pos_d;
        failed_q   <= failed_d;
        finished_q <= finished_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q   <= ent_d;
    rem_q   <= rem_d;
    len_q   <= len_d;
    full1_q <= full1_d;
    quo_q   <= quo_d;
    prt_q   <= prt_d;
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign row_o          = res_q.row;
  assign column_o       = res_q.column;
  assign length_o       = res_q.length;
  assign row_repeat_o   = res_q.row_repeat;
  assign color_o        = res_q.color;
  assign transparent_o  = res_q.transparent;
  assign row_complete_o = res_q.row_complete;
  assign image_done_o   = res_q.image_done;
  assign error_o        = res_q.error;
  assign last_o         = res_q.last;

endmodule

// ----- hdl/nibble_rle_image_decoder.sv -----
// Top level of the nibble run-length image decoder: configuration registers,
// front parser, word queue and segment back end. Uses nrid_pkg.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+--------------------------------
//   in      | input     | in_valid_i / in_stall_o  | nibble, first, stream_end
//   out     | output    | out_valid_o / out_stall_i| row, column, length, row_repeat,
//           |           |                          | color, transparent, row_complete,
//           |           |                          | image_done, error, last
//   cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// The front takes one nibble per cycle into a two-word queue while the queue is not full.
// The back handles one word at a time: a nibble without a run is only popped, an error
// word emits one error result (as does a run that fails its bounds check), and a run is
// checked and then emits one result per segment, its full-row segment after a bit-serial
// divide by width. Reset is asynchronous, active low; no clearing pass. A stalled
// output holds its word while the queue keeps filling; a width or height write restarts.
module nibble_rle_image_decoder import nrid_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [PAL_BITS-1:0]    cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [3:0]             nibble_i,
  input  logic                   first_i,
  input  logic                   stream_end_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [HEIGHT_BITS-1:0] row_o,
  output logic [WIDTH_BITS-1:0]  column_o,
  output logic [WIDTH_BITS-1:0]  length_o,
  output logic [COUNT_BITS-1:0]  row_repeat_o,
  output logic [COLOR_BITS-1:0]  color_o,
  output logic                   transparent_o,
  output logic                   row_complete_o,
  output logic                   image_done_o,
  output logic                   error_o,
  output logic                   last_o
);

  logic [WIDTH_BITS-1:0]  width_q;
  logic [HEIGHT_BITS-1:0] height_q;
  logic [PAL_BITS-1:0]    palette_q;
  logic                   cfg_wr;
  cfg_t                   cfg;
  logic                   q_full, q_empty, push, pop;
  run_t                   push_word, pop_word;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WIDTH_BITS'(1);
      height_q  <= HEIGHT_BITS'(1);
      palette_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        CFG_WIDTH:   width_q   <= cfg_data_i[WIDTH_BITS-1:0];
        CFG_HEIGHT:  height_q  <= cfg_data_i[HEIGHT_BITS-1:0];
        CFG_PALETTE: palette_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.width   = width_q;
    cfg.height  = height_q;
    cfg.palette = palette_q;
    cfg.restart = cfg_wr && ((cfg_index_i == CFG_WIDTH) || (cfg_index_i == CFG_HEIGHT));
  end

  nrid_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .nibble_i     (nibble_i),
    .first_i      (first_i),
    .stream_end_i (stream_end_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .entry_o      (push_word)
  );

  nrid_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_word),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (pop_word),
    .empty_o (q_empty)
  );

  nrid_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .q_empty_i      (q_empty),
    .entry_i        (pop_word),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .row_o          (row_o),
    .column_o       (column_o),
    .length_o       (length_o),
    .row_repeat_o   (row_repeat_o),
    .color_o        (color_o),
    .transparent_o  (transparent_o),
    .row_complete_o (row_complete_o),
    .image_done_o   (image_done_o),
    .error_o        (error_o),
    .last_o         (last_o)
  );

endmodule

// ----- tb/nibble_rle_image_decoder_tb.sv -----
// Testbench for nibble_rle_image_decoder: drives command nibbles and register writes,
// predicts every row segment in a scoreboard class and checks it at the output port.
// Depends on nrid_pkg and the nibble_rle_image_decoder RTL only.
module nibble_rle_image_decoder_tb import nrid_pkg::*;;

  localparam int unsigned RANDOM_ITEMS  = 500;
  localparam int unsigned PHASE_ITEMS   = 40;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned QUIET_LIMIT   = 5000;
  localparam int unsigned PRESSURE_SET  = 4;
  localparam int unsigned CALM_SET      = 8;

  typedef enum logic [2:0] {
    ST_CMD, ST_COLOR, ST_CNT1, ST_CNT_HI, ST_CNT_LO, ST_WORD
  } parse_state_e;

  typedef struct packed {
    logic [HEIGHT_BITS-1:0] row;
    logic [WIDTH_BITS-1:0]  column;
    logic [WIDTH_BITS-1:0]  length;
    logic [COUNT_BITS-1:0]  row_repeat;
    logic [COLOR_BITS-1:0]  color;
    logic                   transparent;
    logic                   row_complete;
    logic                   image_done;
    logic                   error;
    logic                   last;
  } segment_t;

  class image_scoreboard;
    logic [WIDTH_BITS-1:0]  width_q;
    logic [HEIGHT_BITS-1:0] height_q;
    logic [PAL_BITS-1:0]    palette_q;
    parse_state_e           state;
    logic [3:0]             cmd;
    logic [COLOR_BITS-1:0]  run_color;
    logic [COUNT_BITS-1:0]  acc;
    logic [2:0]             nibs_left;
    logic [WIDTH_BITS-1:0]  col;
    logic [HEIGHT_BITS-1:0] row;
    bit                     finished;
    bit                     failed;
    segment_t               segments_due[$];
    int unsigned            failures;
    int unsigned            nibbles;
    int unsigned            segments;
    int unsigned            error_words;
    int unsigned            images;

    function new();
      width_q   = 1;
      height_q  = 1;
      palette_q = '0;
      restart();
    endfunction

    function void restart();
      state     = ST_CMD;
      cmd       = '0;
      run_color = '0;
      acc       = '0;
      nibs_left = '0;
      col       = '0;
      row       = '0;
      finished  = 0;
      failed    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [PAL_BITS-1:0] data);
      case (idx)
        CFG_WIDTH: begin
          width_q = data[WIDTH_BITS-1:0];
          restart();
        end
        CFG_HEIGHT: begin
          height_q = data[HEIGHT_BITS-1:0];
          restart();
        end
        CFG_PALETTE: palette_q = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return segments_due.size();
    endfunction

    function void fail_here();
      segment_t s;
      s        = '0;
      s.row    = row;
      s.column = col;
      s.error  = 1'b1;
      s.last   = 1'b1;
      failed   = 1;
      segments_due.push_back(s);
    endfunction

    function segment_t seg_of(int unsigned r, int unsigned c, int unsigned len,
                              int unsigned rep, bit rc);
      segment_t s;
      s              = '0;
      s.row          = r[HEIGHT_BITS-1:0];
      s.column       = c[WIDTH_BITS-1:0];
      s.length       = len[WIDTH_BITS-1:0];
      s.row_repeat   = rep[COUNT_BITS-1:0];
      s.row_complete = rc;
      return s;
    endfunction

    function void note_input(logic [3:0] nib, bit first, bit ends);
      bit                    have_run;
      bit                    transp;
      bit                    done;
      int unsigned           cnt, w, total, pos, rem, r, c, room, len, rows;
      int                    n;
      logic [COLOR_BITS-1:0] colr;
      segment_t              segs[3];
      segment_t              s;
      if (first) restart();
      if (failed) begin
        nibbles++;
        fail_here();
        return;
      end
      if (finished) return;
      nibbles++;
      have_run = 0;
      cnt      = 0;
      case (state)
        ST_CMD: begin
          cmd = nib;
          if (nib[2:0] == KIND_LITERAL) state = ST_COLOR;
          else begin
            run_color = (nib[2:0] == KIND_SKIP) ? '0 : palette_q[4*nib[2:0] +: COLOR_BITS];
            if (nib[3]) state = ST_CNT1;
            else begin
              cnt      = 1;
              have_run = 1;
            end
          end
        end
        ST_COLOR: begin
          run_color = nib;
          if (cmd[3]) state = ST_CNT1;
          else begin
            cnt      = 1;
            have_run = 1;
          end
        end
        ST_CNT1: begin
          if (nib != CNT_ESCAPE) begin
            cnt      = 32'(COUNT_BITS'(nib) + SHORT_BIAS);
            have_run = 1;
          end else state = ST_CNT_HI;
        end
        ST_CNT_HI: begin
          acc   = {12'h0, nib};
          state = ST_CNT_LO;
        end
        ST_CNT_LO: begin
          acc = {8'h0, acc[3:0], nib};
          if (acc[7:0] != BYTE_ESCAPE) begin
            cnt      = 32'(acc + BYTE_BIAS);
            have_run = 1;
          end else begin
            acc       = '0;
            nibs_left = WORD_NIBBLES;
            state     = ST_WORD;
          end
        end
        ST_WORD: begin
          acc       = {acc[11:0], nib};
          nibs_left = nibs_left - 3'd1;
          if (nibs_left == 0) begin
            cnt      = 32'(acc);
            have_run = 1;
          end
        end
        default: state = ST_CMD;
      endcase
      if (!have_run) begin
        if (ends) fail_here();
        return;
      end
      state = ST_CMD;

      w     = (width_q == 0) ? 1 : (width_q > LINE_PIXELS) ? LINE_PIXELS : width_q;
      total = w * ((height_q == 0) ? 1 : height_q);
      pos   = row * w + col;
      if (cnt == 0 || pos > total || cnt > total - pos) begin
        fail_here();
        return;
      end
      done = (pos + cnt == total);
      if (ends && !done) begin
        fail_here();
        return;
      end

      transp = (cmd[2:0] == KIND_SKIP);
      colr   = transp ? '0 : run_color;
      rem    = cnt;
      r      = 32'(row);
      c      = 32'(col);
      n      = 0;
      if (c != 0) begin
        room    = w - c;
        len     = (rem < room) ? rem : room;
        segs[n] = seg_of(r, c, len, 1, len == room);
        n++;
        rem -= len;
        if (len == room) begin
          r++;
          c = 0;
        end else c += len;
      end
      if (rem >= w) begin
        rows    = rem / w;
        segs[n] = seg_of(r, 0, w, rows, 1);
        n++;
        rem -= rows * w;
        r   += rows;
      end
      if (rem != 0) begin
        segs[n] = seg_of(r, c, rem, 1, 0);
        n++;
        c += rem;
      end
      for (int k = 0; k < n; k++) begin
        s             = segs[k];
        s.color       = colr;
        s.transparent = transp;
        s.last        = (k == n - 1);
        s.image_done  = (k == n - 1) && done;
        segments_due.push_back(s);
      end
      row = r[HEIGHT_BITS-1:0];
      col = c[WIDTH_BITS-1:0];
      if (done) begin
        finished = 1;
        images++;
      end
    endfunction

    function void cmp(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(segment_t got);
      segment_t want;
      if (segments_due.size() == 0) begin
        $error("unexpected word: row %0d column %0d error %0d", got.row, got.column,
               got.error);
        failures++;
        return;
      end
      want = segments_due.pop_front();
      segments++;
      if (want.error) error_words++;
      cmp("row", want.row, got.row);
      cmp("column", want.column, got.column);
      cmp("length", want.length, got.length);
      cmp("row_repeat", want.row_repeat, got.row_repeat);
      cmp("color", want.color, got.color);
      cmp("transparent", want.transparent, got.transparent);
      cmp("row_complete", want.row_complete, got.row_complete);
      cmp("image_done", want.image_done, got.image_done);
      cmp("error", want.error, got.error);
      cmp("last", want.last, got.last);
    endfunction
  endclass

  logic                   clk_i        = 1'b0;
  logic                   rst_ni       = 1'b0;
  logic                   cfg_valid_i  = 1'b0;
  logic                   cfg_ready_o;
  logic [1:0]             cfg_index_i  = CFG_WIDTH;
  logic [PAL_BITS-1:0]    cfg_data_i   = '0;
  logic                   in_valid_i   = 1'b0;
  logic                   in_stall_o;
  logic [3:0]             nibble_i     = '0;
  logic                   first_i      = 1'b0;
  logic                   stream_end_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i  = 1'b0;
  logic [HEIGHT_BITS-1:0] row_o;
  logic [WIDTH_BITS-1:0]  column_o;
  logic [WIDTH_BITS-1:0]  length_o;
  logic [COUNT_BITS-1:0]  row_repeat_o;
  logic [COLOR_BITS-1:0]  color_o;
  logic                   transparent_o;
  logic                   row_complete_o;
  logic                   image_done_o;
  logic                   error_o;
  logic                   last_o;

  image_scoreboard sb;
  logic            calm     = 1'b0;
  logic            hold_req = 1'b0;
  int unsigned     eff_w    = 1;
  int unsigned     eff_h    = 1;
  int unsigned     settings = 0;
  int unsigned     quiet    = 0;
  logic [3:0]      stream_q[$];

  nibble_rle_image_decoder dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({row_o, column_o, length_o, row_repeat_o, color_o, transparent_o,
                       row_complete_o, image_done_o, error_o, last_o});
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
      $display("nibble_rle_image_decoder_tb NOT OK");
      $finish;
    end
  end

  // output side: random stall, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req    <= 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= !calm && ($urandom_range(0, 99) < 37);
    end
  end

  task automatic send_nibble(input logic [3:0] nib, input bit first, input bit ends);
    while (!calm && $urandom_range(0, 99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    nibble_i     <= nib;
    first_i      <= first;
    stream_end_i <= ends;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(nib, first, ends);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [PAL_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input logic [WIDTH_BITS-1:0] w, input logic [HEIGHT_BITS-1:0] h,
                           input logic [PAL_BITS-1:0] pal);
    write_reg(CFG_WIDTH, PAL_BITS'(w));
    write_reg(CFG_HEIGHT, PAL_BITS'(h));
    write_reg(CFG_PALETTE, pal);
    cfg_valid_i <= 1'b0;
    eff_w = (w == 0) ? 1 : (w > LINE_PIXELS) ? LINE_PIXELS : w;
    eff_h = (h == 0) ? 1 : h;
    settings++;
  endtask

  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic int unsigned pick_count(int unsigned left);
    int unsigned c;
    case ($urandom_range(0, 9))
      0, 1, 2: c = 1;
      3, 4, 5: c = $urandom_range(2, 16);
      6, 7:    c = $urandom_range(17, 271);
      8:       c = $urandom_range(272, 65535);
      default: c = left;
    endcase
    if (c > left) c = left;
    if (c > 65535) c = 65535;
    return c;
  endfunction

  // command nibble, optional literal colour, then the shortest count code or a word code
  function automatic void push_run(input logic [2:0] kind, input int unsigned c);
    bit         as_word;
    logic [15:0] v;
    as_word = (c == 0) || (c > 271) || ($urandom_range(0, 6) == 0);
    v       = c[15:0];
    stream_q.push_back({(c != 1) || as_word, kind});
    if (kind == KIND_LITERAL) stream_q.push_back(4'($urandom_range(0, 15)));
    if (as_word) begin
      stream_q.push_back(CNT_ESCAPE);
      stream_q.push_back(BYTE_ESCAPE[7:4]);
      stream_q.push_back(BYTE_ESCAPE[3:0]);
      for (int i = 3; i >= 0; i--) stream_q.push_back(v[4*i +: 4]);
    end else if (c >= 17) begin
      v = 16'(c - 17);
      stream_q.push_back(CNT_ESCAPE);
      stream_q.push_back(v[7:4]);
      stream_q.push_back(v[3:0]);
    end else if (c >= 2) begin
      stream_q.push_back(4'(c - 2));
    end
  endfunction

  task automatic send_image(input bit broken);
    int unsigned left, c, runs, max_runs;
    int          end_at;
    bit          with_first;
    stream_q.delete();
    left     = eff_w * eff_h;
    max_runs = $urandom_range(1, 10);
    runs     = 0;
    while (left != 0 && runs < max_runs) begin
      c = pick_count(left);
      if (broken && $urandom_range(0, 3) == 0) c = $urandom_range(0, 1) ? 0 : left + 1;
      push_run(3'($urandom_range(0, 7)), c);
      left = (c < left) ? left - c : 0;
      runs++;
    end
    with_first = ($urandom_range(0, 9) != 0);
    end_at     = $urandom_range(0, 1) ? stream_q.size() - 1 : stream_q.size();
    if (broken && $urandom_range(0, 2) == 0) end_at = $urandom_range(0, stream_q.size() - 1);
    if (broken && $urandom_range(0, 2) == 0)
      stream_q[$urandom_range(0, stream_q.size() - 1)] = 4'($urandom_range(0, 15));
    if (left == 0 && $urandom_range(0, 3) == 0) stream_q.push_back(4'($urandom_range(0, 15)));
    foreach (stream_q[i]) send_nibble(stream_q[i], with_first && i == 0, i == end_at);
  endtask

  initial begin : main_seq
    int unsigned set_no;
    int unsigned start_items;
    int unsigned set_start;
    logic [WIDTH_BITS-1:0]  w;
    logic [HEIGHT_BITS-1:0] h;
    logic [PAL_BITS-1:0]    pal;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: 5x4 image, palette, literal and skip commands, count codes, and the error paths
    configure(9'd5, 16'd4, 24'hF0A5C3);
    send_nibble(4'h0, 1, 0); send_nibble(4'h7, 0, 0); send_nibble(4'hF, 0, 0);
    send_nibble(4'h6, 0, 0); send_nibble(4'h9, 0, 0); send_nibble(4'h3, 0, 0);
    send_nibble(4'hE, 0, 0); send_nibble(4'h0, 0, 0); send_nibble(4'hA, 0, 0);
    send_nibble(4'h8, 0, 0);
    send_nibble(4'h0, 0, 0);   // ignored after image done
    send_nibble(4'hF, 1, 0); send_nibble(4'hF, 0, 0); send_nibble(4'hF, 0, 0);
    send_nibble(4'hF, 0, 0); send_nibble(4'hF, 0, 0);
    repeat (4) send_nibble(4'h0, 0, 0);   // zero count
    send_nibble(4'h5, 0, 0);   // still failed
    send_nibble(4'h1, 1, 1);   // early stream end
    send_nibble(4'h8, 1, 0); send_nibble(4'hF, 0, 0); send_nibble(4'h0, 0, 0);
    send_nibble(4'h5, 0, 0);   // 22 pixels overflow
    send_nibble(4'hC, 1, 0); send_nibble(4'hF, 0, 0); send_nibble(4'h0, 0, 0);
    send_nibble(4'h3, 0, 1);   // whole image with stream end
    drain_block();

    start_items = sb.nibbles;
    set_no      = 0;
    while (sb.nibbles - start_items < RANDOM_ITEMS) begin
      w   = WIDTH_BITS'($urandom_range(1, 24));
      h   = HEIGHT_BITS'($urandom_range(1, 8));
      pal = PAL_BITS'($urandom);
      case (set_no)
        0: begin w = 1;   h = 1;     pal = '0;  end
        1: begin w = 320; h = 2;     pal = '1;  end
        2: begin w = 0;   h = 0;     end
        3: begin w = 511; h = 3;     end
        5: begin w = 1;   h = 65535; end
        6: begin w = 320; h = 65535; end
        7: begin w = 321; h = 1;     end
        default: ;
      endcase
      configure(w, h, pal);
      calm <= (set_no == PRESSURE_SET) || (set_no == CALM_SET);
      if (set_no == PRESSURE_SET) hold_req <= 1'b1;
      set_start = sb.nibbles;
      while (sb.nibbles - set_start < PHASE_ITEMS) send_image($urandom_range(0, 4) == 0);
      drain_block();
      calm <= 1'b0;
      set_no++;
    end

    $display("covered %0d nibbles over %0d register settings, %0d words checked",
             sb.nibbles, settings, sb.segments);
    $display("%0d images finished, %0d error words", sb.images, sb.error_words);
    if (sb.failures == 0) $display("nibble_rle_image_decoder_tb OK");
    else $display("nibble_rle_image_decoder_tb NOT OK");
    $finish;
  end

endmodule

// ----- nibble_rle_image_decoder.f -----
hdl/nrid_pkg.sv
hdl/nrid_fifo.sv
hdl/nrid_front.sv
hdl/nrid_back.sv
hdl/nibble_rle_image_decoder.sv
tb/nibble_rle_image_decoder_tb.sv
